// ===== hdl/packet_receipt_tracker_nak_ranges_core_defines.svh =====
// assertion macros for the tracker rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PACKET_RECEIPT_TRACKER_NAK_RANGES_CORE_DEFINES_SVH
`define PACKET_RECEIPT_TRACKER_NAK_RANGES_CORE_DEFINES_SVH

// same-cycle implication
`define PRTN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prtn assertion failed");

// next-cycle implication
`define PRTN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prtn assertion failed");

`endif

// ===== hdl/prtn_pkg.sv =====
// shared types, constants and helpers for the packet receipt tracker
// no dependencies
package prtn_pkg;

    localparam int unsigned MAX_PACKETS = 1024;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ROWS        = MAX_PACKETS / WORD_W;
    localparam int unsigned ROW_W       = $clog2(ROWS);
    localparam int unsigned BIT_W       = $clog2(WORD_W);
    localparam int unsigned IDX_W       = ROW_W + BIT_W;
    localparam int unsigned CNT_W       = IDX_W + 1;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned IN_W        = 24;
    localparam int unsigned OUT_W       = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKETS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_RD_INS,
        ST_INS,
        ST_RD_FIND,
        ST_FIND,
        ST_RD_SPAN,
        ST_SPAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic read;
        logic insert;
        logic find;
        logic span;
        logic clear;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            hit;
        logic            stop_hit;
        logic            more;
        logic            out_free;
    } t_sts;

    // lowest set bit: {any, position}
    function automatic logic [BIT_W:0] f_first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        logic             any;
        pos = '0;
        any = 1'b0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_W'(i);
                any = 1'b1;
            end
        end
        return {any, pos};
    endfunction

endpackage

// ===== hdl/prtn_ctrl.sv =====
// controller state machine for the packet receipt tracker
// depends on prtn_pkg; drives prtn_dp through command and status structs
module prtn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  prtn_pkg::t_sts  i_sts,
    output prtn_pkg::t_cmd  o_cmd
);

    prtn_pkg::t_state r_state;
    prtn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prtn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            prtn_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = prtn_pkg::ST_DISP;
                end
            end
            prtn_pkg::ST_DISP: begin
                if (i_sts.op == prtn_pkg::OP_INSERT && i_sts.in_range) begin
                    n_state = prtn_pkg::ST_RD_INS;
                end else if (i_sts.op == prtn_pkg::OP_QUERY && i_sts.in_range) begin
                    n_state = prtn_pkg::ST_RD_FIND;
                end else begin
                    n_state = prtn_pkg::ST_DONE;
                end
            end
            prtn_pkg::ST_RD_INS:  n_state = prtn_pkg::ST_INS;
            prtn_pkg::ST_INS:     n_state = prtn_pkg::ST_DONE;
            prtn_pkg::ST_RD_FIND: n_state = prtn_pkg::ST_FIND;
            prtn_pkg::ST_FIND: begin
                if (i_sts.hit) begin
                    n_state = prtn_pkg::ST_SPAN;
                end else if (i_sts.more) begin
                    n_state = prtn_pkg::ST_RD_FIND;
                end else begin
                    n_state = prtn_pkg::ST_DONE;
                end
            end
            prtn_pkg::ST_RD_SPAN: n_state = prtn_pkg::ST_SPAN;
            prtn_pkg::ST_SPAN: begin
                if (!i_sts.stop_hit && i_sts.more) begin
                    n_state = prtn_pkg::ST_RD_SPAN;
                end else begin
                    n_state = prtn_pkg::ST_DONE;
                end
            end
            prtn_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = prtn_pkg::ST_IDLE;
                end
            end
            default: n_state = prtn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            prtn_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = i_s_axis_tvalid;
            end
            prtn_pkg::ST_DISP: begin
                o_cmd.clear = (i_sts.op == prtn_pkg::OP_CLEAR);
            end
            prtn_pkg::ST_RD_INS:  o_cmd.read   = 1'b1;
            prtn_pkg::ST_INS:     o_cmd.insert = 1'b1;
            prtn_pkg::ST_RD_FIND: o_cmd.read   = 1'b1;
            prtn_pkg::ST_FIND:    o_cmd.find   = 1'b1;
            prtn_pkg::ST_RD_SPAN: o_cmd.read   = 1'b1;
            prtn_pkg::ST_SPAN:    o_cmd.span   = 1'b1;
            prtn_pkg::ST_DONE:    o_cmd.emit   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/prtn_dp.sv =====
// datapath of the packet receipt tracker: slot word store, row valid bits,
// good tally, word scan and result register; depends on prtn_pkg and the defines header
`include "packet_receipt_tracker_nak_ranges_core_defines.svh"

module prtn_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [prtn_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic [prtn_pkg::IN_W-1:0]     i_s_axis_tdata,
    input  logic [prtn_pkg::OP_W-1:0]     i_s_axis_tuser,
    input  prtn_pkg::t_cmd                i_cmd,
    output prtn_pkg::t_sts                o_sts,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [prtn_pkg::OUT_W-1:0]    o_m_axis_tdata
);

    localparam int unsigned WW = prtn_pkg::WORD_W;
    localparam int unsigned RW = prtn_pkg::ROW_W;
    localparam int unsigned BW = prtn_pkg::BIT_W;
    localparam int unsigned XW = prtn_pkg::IDX_W;
    localparam int unsigned CW = prtn_pkg::CNT_W;

    logic [WW-1:0] r_mem [prtn_pkg::ROWS];
    logic [prtn_pkg::ROWS-1:0] r_valid;

    logic [CW-1:0]               r_total;
    logic [prtn_pkg::OP_W-1:0]   r_op;
    logic [XW-1:0]               r_idx;
    logic                        r_good;
    logic [XW-1:0]               r_start;
    logic [RW-1:0]               r_word;
    logic [WW-1:0]               r_rd_data;
    logic                        r_rd_valid;
    logic [CW-1:0]               r_tally;
    logic                        r_acc;
    logic                        r_found;
    logic [XW-1:0]               r_first;
    logic [XW-1:0]               r_last;
    logic                        r_out_valid;
    logic                        r_out_acc;
    logic [CW-1:0]               r_out_cnt;
    logic                        r_out_cmpl;
    logic                        r_out_found;
    logic [XW-1:0]               r_out_first;
    logic [XW-1:0]               r_out_last;

    logic [CW-1:0] eff;
    logic [WW-1:0] data_eff;
    logic [WW-1:0] lt_eff;
    logic [WW-1:0] ge_start;
    logic [WW-1:0] gt_first;
    logic [BW:0]   hit_enc;
    logic [BW:0]   stop_enc;
    logic [CW-1:0] next_base;
    logic          more;
    logic          was_good;
    logic [WW-1:0] n_word;
    logic [XW-1:0] slot;

    assign eff      = (r_total > prtn_pkg::MAX_CNT) ? prtn_pkg::MAX_CNT : r_total;
    assign data_eff = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        slot = '0;
        for (int b = 0; b < WW; b++) begin
            slot        = {r_word, BW'(b)};
            lt_eff[b]   = ({1'b0, slot} < eff);
            ge_start[b] = (slot >= r_start);
            gt_first[b] = (slot > r_first);
        end
    end

    assign hit_enc   = prtn_pkg::f_first_set(~data_eff & ge_start & lt_eff);
    assign stop_enc  = prtn_pkg::f_first_set((data_eff | ~lt_eff) & gt_first);
    assign next_base = {({1'b0, r_word} + 1'b1), {BW{1'b0}}};
    assign more      = (next_base < eff);
    assign was_good  = data_eff[r_idx[BW-1:0]];

    always_comb begin
        n_word                  = data_eff;
        n_word[r_idx[BW-1:0]]   = r_good;
    end

    assign o_sts.op       = r_op;
    assign o_sts.in_range = (r_op == prtn_pkg::OP_INSERT) ? ({1'b0, r_idx} < eff)
                                                          : ({1'b0, r_start} < eff);
    assign o_sts.hit      = hit_enc[BW];
    assign o_sts.stop_hit = stop_enc[BW];
    assign o_sts.more     = more;
    assign o_sts.out_free = !r_out_valid || i_m_axis_tready;

    // slot word store
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_word];
        end
        if (i_cmd.insert) begin
            r_mem[r_word] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_tally    <= '0;
            r_total    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_rd_valid <= r_valid[r_word];
            end
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
                r_valid <= '0;
                r_tally <= '0;
            end else if (i_cmd.clear) begin
                r_valid <= '0;
                r_tally <= '0;
            end else if (i_cmd.insert) begin
                r_valid[r_word] <= 1'b1;
                if (r_good && !was_good) begin
                    r_tally <= r_tally + 1'b1;
                end else if (!r_good && was_good && r_tally != '0) begin
                    r_tally <= r_tally - 1'b1;
                end
            end
        end
    end

    // item capture and scan progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_s_axis_tuser;
            r_idx   <= i_s_axis_tdata[XW-1:0];
            r_good  <= i_s_axis_tdata[XW];
            r_start <= i_s_axis_tdata[2*XW:XW+1];
            r_word  <= (i_s_axis_tuser == prtn_pkg::OP_INSERT) ? i_s_axis_tdata[XW-1:BW]
                                                              : i_s_axis_tdata[2*XW:XW+1+BW];
            r_acc   <= 1'b0;
            r_found <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_acc <= 1'b1;
            end
            if (i_cmd.find) begin
                if (hit_enc[BW]) begin
                    r_found <= 1'b1;
                    r_first <= {r_word, hit_enc[BW-1:0]};
                end else if (more) begin
                    r_word <= r_word + 1'b1;
                end
            end
            if (i_cmd.span) begin
                if (stop_enc[BW]) begin
                    r_last <= {r_word, stop_enc[BW-1:0]} - 1'b1;
                end else if (more) begin
                    r_word <= r_word + 1'b1;
                end else begin
                    r_last <= XW'(eff - 1'b1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_acc   <= r_acc;
            r_out_cnt   <= r_tally;
            r_out_cmpl  <= (eff != '0) && (r_tally == eff);
            r_out_found <= r_found;
            r_out_first <= r_first;
            r_out_last  <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_last, r_out_first, r_out_found, r_out_cmpl,
                              r_out_cnt, r_out_acc};

    `PRTN_ASSERT_IMP(a_tally_bound, i_clk, i_rst_n, 1'b1, r_tally <= prtn_pkg::MAX_CNT)
    `PRTN_ASSERT_NXT(a_clear_zero, i_clk, i_rst_n, i_cmd.clear, r_tally == '0)
    `PRTN_ASSERT_IMP(a_run_order, i_clk, i_rst_n, r_out_valid && r_out_found,
                     r_out_first <= r_out_last)
    `PRTN_ASSERT_IMP(a_acc_xor_found, i_clk, i_rst_n, r_out_valid,
                     !(r_out_acc && r_out_found))

endmodule

// ===== hdl/packet_receipt_tracker_nak_ranges_core.sv =====
// top level of the packet receipt tracker with nak range search
// depends on prtn_pkg, prtn_ctrl and prtn_dp
//
//  channel   dir  handshake                    payload
//  s_axis    in   i_s_axis_tvalid/o_..._tready  tdata 24b, tuser 2b (operation)
//  m_axis    out  o_m_axis_tvalid/i_..._tready  tdata 40b
//  cfg       in   i_cfg_we                      i_cfg_wdata 11b (slot count)
//
// one request at a time; an insert reads its 32-slot word from the single-port slot
// store and writes it back; a query reads word by word to the first missing slot,
// then to the end of the run; clears, unused codes and out-of-range requests skip it
// reset (i_rst_n low, synchronous) and a cfg write empty the store at once
// through per-word valid bits; a waiting result does not block the next accept
module packet_receipt_tracker_nak_ranges_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [prtn_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // slot index, packet good, scan start, zero fill
    input  logic [prtn_pkg::IN_W-1:0]   i_s_axis_tdata,
    // operation
    input  logic [prtn_pkg::OP_W-1:0]   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // accepted, good_count, complete, range_found, range_first, range_last, zero fill
    output logic [prtn_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    prtn_pkg::t_cmd cmd;
    prtn_pkg::t_sts sts;

    prtn_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    prtn_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== verif/tb_packet_receipt_tracker_nak_ranges_core.sv =====
// self-checking testbench for packet_receipt_tracker_nak_ranges_core: inserts, nak walks,
// clears and total writes over random stream stalls, checked against an in-bench tracker
// depends on prtn_pkg and the tracker rtl
module tb_packet_receipt_tracker_nak_ranges_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OP_W        = prtn_pkg::OP_W;
    localparam int unsigned IDX_W       = prtn_pkg::IDX_W;
    localparam int unsigned CNT_W       = prtn_pkg::CNT_W;
    localparam int unsigned IN_W        = prtn_pkg::IN_W;
    localparam int unsigned OUT_W       = prtn_pkg::OUT_W;
    localparam int unsigned MAX_PACKETS = prtn_pkg::MAX_PACKETS;
    localparam logic [OP_W-1:0] OP_INSERT = prtn_pkg::OP_INSERT;
    localparam logic [OP_W-1:0] OP_QUERY  = prtn_pkg::OP_QUERY;
    localparam logic [OP_W-1:0] OP_CLEAR  = prtn_pkg::OP_CLEAR;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned REQUEST_TARGET = 700;

    // fields from the highest bit down
    typedef struct packed {
        logic [IDX_W-1:0] range_last;
        logic [IDX_W-1:0] range_first;
        logic             range_found;
        logic             complete;
        logic [CNT_W-1:0] good_count;
        logic             accepted;
    } t_status;

    localparam int unsigned STATUS_W = $bits(t_status);

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    // slot index, packet good, scan start, zero fill
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    // operation
    logic [OP_W-1:0]   i_s_axis_tuser = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // accepted, good_count, complete, range_found, range_first, range_last, zero fill
    logic [OUT_W-1:0]  o_m_axis_tdata;

    packet_receipt_tracker_nak_ranges_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // tracker state mirrored in the bench
    logic [CNT_W-1:0] slot_total;
    bit               slot_received [MAX_PACKETS];
    bit               slot_good [MAX_PACKETS];
    int unsigned      good_tally;

    t_status     pending_status [$];
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned completions_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned op_counts [4] = '{0, 0, 0, 0};
    int unsigned transfers = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_stalls = 1'b1;
    int unsigned stall_left = 0;
    t_status     got_status;
    t_status     want_status;

    function automatic int unsigned active_total();
        return (slot_total > MAX_PACKETS) ? MAX_PACKETS : int'(slot_total);
    endfunction

    function automatic void empty_slots();
        foreach (slot_received[k]) begin
            slot_received[k] = 1'b0;
            slot_good[k] = 1'b0;
        end
        good_tally = 0;
    endfunction

    function automatic bit slot_missing(int unsigned k);
        return !slot_received[k] || !slot_good[k];
    endfunction

    function automatic t_status track_update(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic good, logic [IDX_W-1:0] from);
        t_status     st;
        int unsigned total;
        int unsigned i;
        int unsigned j;
        bit          was_good;
        st = '0;
        total = active_total();
        case (op)
            OP_INSERT: begin
                if (idx < total) begin
                    was_good = slot_received[idx] && slot_good[idx];
                    slot_received[idx] = 1'b1;
                    slot_good[idx] = good;
                    if (good && !was_good)
                        good_tally++;
                    else if (!good && was_good && good_tally > 0)
                        good_tally--;
                    st.accepted = 1'b1;
                end
            end
            OP_QUERY: begin
                i = from;
                while (i < total && !slot_missing(i))
                    i++;
                if (i < total) begin
                    j = i;
                    while (j + 1 < total && slot_missing(j + 1))
                        j++;
                    st.range_found = 1'b1;
                    st.range_first = IDX_W'(i);
                    st.range_last = IDX_W'(j);
                end
            end
            OP_CLEAR: empty_slots();
            default: ;
        endcase
        st.good_count = CNT_W'(good_tally);
        st.complete = (total > 0 && good_tally == total);
        return st;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!sender_idles || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic good, input logic [IDX_W-1:0] from,
                                output t_status st);
        int unsigned gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, from, good, idx};
        i_s_axis_tuser <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        st = track_update(op, idx, good, from);
        pending_status.insert(pending_status.size(), st);
        requests_sent++;
        op_counts[op]++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_noise();
        t_status     st;
        int unsigned r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 99);
        op = (r < 45) ? OP_INSERT : (r < 85) ? OP_QUERY : (r < 93) ? OP_UNUSED : OP_CLEAR;
        send_request(op, IDX_W'($urandom_range(0, 1023)), 1'($urandom),
                     IDX_W'($urandom_range(0, 1023)), st);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_total(input logic [CNT_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        slot_total = value;
        empty_slots();
        transfers++;
    endtask

    // receiver back pressure
    always @(negedge i_clk) begin
        if (!receiver_stalls) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    i_m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(10, 30);
                end
                1, 2, 3, 4: begin
                    i_m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(0, 3);
                end
                default: i_m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_status = t_status'(o_m_axis_tdata[STATUS_W-1:0]);
            if (got_status.complete)
                completions_seen++;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no request waiting: %p", $realtime, got_status);
            end else begin
                want_status = pending_status.pop_front();
                results_checked++;
                if (got_status !== want_status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                                 $realtime, want_status, got_status);
                end
            end
        end
    end

    task automatic test_after_reset();
        t_status st;
        send_request(OP_INSERT, 10'd0, 1'b1, 10'd0, st);
        send_request(OP_INSERT, 10'd1023, 1'b1, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd1023, st);
        send_request(OP_UNUSED, 10'd1023, 1'b1, 10'd1023, st);
        send_request(OP_CLEAR, 10'd0, 1'b0, 10'd0, st);
    endtask

    task automatic test_single_slot();
        t_status st;
        write_total(11'd1);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_INSERT, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_INSERT, 10'd0, 1'b1, 10'd0, st);
        send_request(OP_INSERT, 10'd0, 1'b1, 10'd0, st);
        send_request(OP_INSERT, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_INSERT, 10'd1, 1'b1, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd1, st);
        send_request(OP_INSERT, 10'd0, 1'b1, 10'd0, st);
        send_request(OP_UNUSED, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_CLEAR, 10'd0, 1'b0, 10'd0, st);
    endtask

    task automatic test_full_size();
        t_status st;
        write_total(11'd1024);
        send_request(OP_INSERT, 10'd1023, 1'b1, 10'd0, st);
        send_request(OP_INSERT, 10'd0, 1'b1, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd1023, st);
        send_request(OP_INSERT, 10'd512, 1'b0, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd513, st);
        write_total(11'd2047);
        send_request(OP_INSERT, 10'd1023, 1'b1, 10'd0, st);
        send_request(OP_QUERY, 10'd0, 1'b0, 10'd1000, st);
    endtask

    task automatic test_random_transfers();
        t_status     st;
        int unsigned total;
        int unsigned r;
        int unsigned from;
        int unsigned k;
        int unsigned pick;
        int unsigned spare;
        int unsigned walk_first [$];
        int unsigned walk_last [$];
        int unsigned order [$];
        while (requests_sent < REQUEST_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                write_total(11'd0);
            else if (r < 60)
                write_total(CNT_W'($urandom_range(1, 48)));
            else if (r < 85)
                write_total(CNT_W'($urandom_range(49, 300)));
            else if (r < 93)
                write_total(CNT_W'($urandom_range(301, 1024)));
            else
                write_total(CNT_W'($urandom_range(1025, 2047)));
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            total = active_total();
            repeat ($urandom_range(1, 3)) begin
                order.delete();
                if (total <= 64) begin
                    for (k = 0; k < total; k++)
                        order.insert(order.size(), k);
                    for (k = order.size(); k > 1; k--) begin
                        pick = $urandom_range(0, k - 1);
                        spare = order[k - 1];
                        order[k - 1] = order[pick];
                        order[pick] = spare;
                    end
                end else begin
                    repeat ($urandom_range(20, 60))
                        order.insert(order.size(), $urandom_range(0, total - 1));
                end
                foreach (order[k]) begin
                    if ($urandom_range(0, 9) == 0)
                        send_noise();
                    send_request(OP_INSERT, IDX_W'(order[k]), $urandom_range(0, 99) < 80,
                                 IDX_W'($urandom), st);
                end
                // walk the nak list
                walk_first.delete();
                walk_last.delete();
                from = ($urandom_range(0, 4) == 0 && total > 0) ? $urandom_range(0, total - 1) : 0;
                repeat (12) begin
                    send_request(OP_QUERY, IDX_W'($urandom), 1'($urandom), IDX_W'(from), st);
                    if (!st.range_found || st.range_last + 1 >= total)
                        break;
                    walk_first.insert(walk_first.size(), st.range_first);
                    walk_last.insert(walk_last.size(), st.range_last);
                    from = st.range_last + 1;
                end
                if (st.range_found) begin
                    walk_first.insert(walk_first.size(), st.range_first);
                    walk_last.insert(walk_last.size(), st.range_last);
                end
                // resend up to the first 8 slots of each reported range
                foreach (walk_first[k]) begin
                    for (from = walk_first[k];
                         from <= walk_last[k] && from < walk_first[k] + 8; from++)
                        send_request(OP_INSERT, IDX_W'(from), $urandom_range(0, 9) != 0,
                                     IDX_W'($urandom), st);
                end
                send_request(OP_QUERY, IDX_W'($urandom), 1'($urandom), 10'd0, st);
                if ($urandom_range(0, 9) == 0)
                    send_request(OP_CLEAR, IDX_W'($urandom), 1'($urandom),
                                 IDX_W'($urandom), st);
            end
        end
    endtask

    initial begin
        slot_total = '0;
        empty_slots();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_single_slot();
        test_full_size();
        test_random_transfers();
        wait_idle();
        repeat (80) @(posedge i_clk);
        $display("%0d requests: %0d inserts, %0d queries, %0d clears, %0d unused codes",
                 requests_sent, op_counts[OP_INSERT], op_counts[OP_QUERY],
                 op_counts[OP_CLEAR], op_counts[OP_UNUSED]);
        $display("%0d transfers, %0d results checked, %0d with completion, %0d mismatches",
                 transfers, results_checked, completions_seen, mismatches);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_status.size());
        $display("Verification failed");
        $finish;
    end

endmodule
